FILE: hw/rtl/shns_pkg.sv
// ----------------------------------------------------------------------------
// shns_pkg
// Types and constants shared by the spatial hash neighbour search block.
// ----------------------------------------------------------------------------
`default_nettype none

package shns_pkg;

    localparam int POS_W  = 32;
    localparam int ID_W   = 16;
    localparam int LEN_W  = 31;
    localparam int STAT_W = 2;

    localparam int MAX_HITS = 64;
    localparam int HITS_W   = 7;

    localparam logic [31:0] HASH_PX = 32'd73856093;
    localparam logic [31:0] HASH_PY = 32'd19349663;
    localparam logic [31:0] HASH_PZ = 32'd83492791;

    localparam logic [LEN_W-1:0] CELL_LEN_RST = 31'd65536;

    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_FOUND    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE     = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
    } t_entry;

endpackage

`default_nettype wire

FILE: hw/rtl/spatial_hash_neighbour_search.sv
// ----------------------------------------------------------------------------
// spatial_hash_neighbour_search
// Hash grid of Q16.16 particles with insert and 27-cell neighbour query.
// ----------------------------------------------------------------------------
// Input words (op, id, position) arrive on i_in_valid / o_in_ready; result
// words leave on o_out_valid / i_out_ready through an output register.
// i_cfg_we writes cell_length, 0 acting as 1; the user must only do so
// while idle (not enforced by the block). One word is worked on at a time;
// o_in_ready is high only when idle. Multiplies and divides use one 32x32
// multiplier and one radix-2 divider under a sequencer; the bucket index
// is the hash reduced by a reciprocal multiply and at most two subtracts.
//   insert: cell divides, hash and bucket lookup, one result word.
//   query : cell divides, then hash and bucket scan for each of 27 cells,
//           with up to three more divides for each entry within the radius.
// A query gives one word per match (at most 64, last flagged, truncated set
// when more existed) or one "no neighbours" word.
// After reset the bucket counts are cleared in a pass over all TABLE_SIZE
// buckets, during which o_in_ready stays low.
// When the receiver stalls, the sequencer waits at its next result word.
// ----------------------------------------------------------------------------
`default_nettype none

module spatial_hash_neighbour_search #(
    parameter int TABLE_SIZE   = 1024,
    parameter int BUCKET_DEPTH = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [shns_pkg::LEN_W-1:0]    i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire                          i_op,
    input  wire [shns_pkg::ID_W-1:0]     i_item_id,
    input  wire signed [shns_pkg::POS_W-1:0] i_pos_x,
    input  wire signed [shns_pkg::POS_W-1:0] i_pos_y,
    input  wire signed [shns_pkg::POS_W-1:0] i_pos_z,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [shns_pkg::STAT_W-1:0]  o_status,
    output logic [shns_pkg::ID_W-1:0]    o_neighbour_id,
    output logic [shns_pkg::ID_W-1:0]    o_query_id,
    output logic                         o_last,
    output logic                         o_truncated
);
    import shns_pkg::*;

    localparam int HW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int AW = (TABLE_SIZE * BUCKET_DEPTH > 1) ?
                        $clog2(TABLE_SIZE * BUCKET_DEPTH) : 1;
    localparam int FW = $clog2(BUCKET_DEPTH + 1);
    localparam int DEPTH = TABLE_SIZE * BUCKET_DEPTH;

    // floor((2^32-1)/TABLE_SIZE): quotient estimate is low by at most two
    localparam logic [31:0] RECIP = 32'(64'hFFFF_FFFF / 64'(TABLE_SIZE));
    localparam logic [31:0] TBL32 = 32'(TABLE_SIZE);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DIV   = 5'd2;
    localparam logic [4:0] S_CELL  = 5'd3;
    localparam logic [4:0] S_LIM   = 5'd4;
    localparam logic [4:0] S_LIMW  = 5'd5;
    localparam logic [4:0] S_HMUL  = 5'd6;
    localparam logic [4:0] S_HACC  = 5'd7;
    localparam logic [4:0] S_FREAD = 5'd8;
    localparam logic [4:0] S_FWAIT = 5'd9;
    localparam logic [4:0] S_ENEXT = 5'd10;
    localparam logic [4:0] S_ECHK  = 5'd11;
    localparam logic [4:0] S_SQ    = 5'd12;
    localparam logic [4:0] S_SQACC = 5'd13;
    localparam logic [4:0] S_SQCMP = 5'd14;
    localparam logic [4:0] S_ECELL = 5'd15;
    localparam logic [4:0] S_HIT   = 5'd16;
    localparam logic [4:0] S_NADV  = 5'd17;
    localparam logic [4:0] S_FIN   = 5'd18;
    localparam logic [4:0] S_MQ    = 5'd19;
    localparam logic [4:0] S_MQW   = 5'd20;
    localparam logic [4:0] S_MR    = 5'd21;
    localparam logic [4:0] S_MRW   = 5'd22;
    localparam logic [4:0] S_MFIX  = 5'd23;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? 32'(-v) : v;
    endfunction

    // control
    logic [4:0]        r_state;
    logic [4:0]        r_ret;
    logic [HW-1:0]     r_ci;
    logic [1:0]        r_ax;
    logic [1:0]        r_d [0:2];
    logic [5:0]        r_dcnt;
    logic [FW-1:0]     r_n;
    logic [FW-1:0]     r_e;
    logic [HITS_W-1:0] r_hits;
    logic              r_more;
    logic              r_pend_v;
    logic              r_o_valid;

    // datapath
    logic [LEN_W-1:0]  r_cell_len;
    logic              r_op;
    logic [ID_W-1:0]   r_qid;
    logic [31:0]       r_p [0:2];
    logic [31:0]       r_c [0:2];
    logic [63:0]       r_lim;
    logic [63:0]       r_prod;
    logic [31:0]       r_hash;
    logic [HW-1:0]     r_h;
    logic [31:0]       r_dq;
    logic [31:0]       r_dsr;
    logic [31:0]       r_rem;
    logic              r_neg;
    logic [31:0]       r_dd [0:2];
    logic [63:0]       r_acc;
    logic [ID_W-1:0]   r_pend_id;
    logic [FW-1:0]     r_fill_q;
    t_entry            r_ent;
    logic [STAT_W-1:0] r_o_status;
    logic [ID_W-1:0]   r_o_nid;
    logic [ID_W-1:0]   r_o_qid;
    logic              r_o_last;
    logic              r_o_trunc;

    logic [FW-1:0]     fill_mem [0:TABLE_SIZE-1];
    t_entry            ent_mem  [0:DEPTH-1];

    logic [31:0] len_eff;
    logic        out_free;
    logic        out_load;
    logic [32:0] ncell [0:2];
    logic [31:0] ent_p [0:2];
    logic [31:0] prime [0:2];
    logic [32:0] qcell;
    logic [31:0] trial;
    logic        trial_ge;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [32:0] adiff [0:2];
    logic        near;
    logic [AW-1:0] ent_addr;
    logic        fill_full;
    logic        ins_we;

    assign len_eff  = (r_cell_len == '0) ? 32'd1 : {1'b0, r_cell_len};
    assign out_free = !r_o_valid || i_out_ready;

    assign prime[0] = HASH_PX;
    assign prime[1] = HASH_PY;
    assign prime[2] = HASH_PZ;

    assign ent_p[0] = r_ent.x;
    assign ent_p[1] = r_ent.y;
    assign ent_p[2] = r_ent.z;

    // neighbour cell: own cell plus d - 1
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            ncell[a] = {r_c[a][31], r_c[a]} + {31'd0, r_d[a]} - 33'd1;
        end
    end

    // signed quotient of the last division
    assign qcell = r_neg ? 33'(-{1'b0, r_dq}) : {1'b0, r_dq};

    assign trial    = {r_rem[30:0], r_dq[31]};
    assign trial_ge = trial >= r_dsr;

    always_comb begin
        mul_a = len_eff;
        mul_b = len_eff;
        case (r_state)
            S_HMUL: begin
                mul_a = ncell[r_ax][31:0];
                mul_b = prime[r_ax];
            end
            S_SQ: begin
                mul_a = r_dd[r_ax];
                mul_b = r_dd[r_ax];
            end
            S_MQ: begin
                mul_a = r_dq;
                mul_b = RECIP;
            end
            S_MR: begin
                mul_a = r_rem;
                mul_b = TBL32;
            end
            default: begin
                mul_a = len_eff;
                mul_b = len_eff;
            end
        endcase
    end

    always_comb begin
        near = 1'b1;
        for (int a = 0; a < 3; a++) begin
            adiff[a] = {ent_p[a][31], ent_p[a]} - {r_p[a][31], r_p[a]};
            if (adiff[a][32]) begin
                adiff[a] = 33'(-adiff[a]);
            end
            if (adiff[a] >= {1'b0, len_eff}) begin
                near = 1'b0;
            end
        end
    end

    assign ent_addr  = AW'(AW'(r_h) * AW'(BUCKET_DEPTH)) + AW'(r_e);
    assign fill_full = r_fill_q >= FW'(BUCKET_DEPTH);
    assign ins_we    = (r_state == S_FWAIT) && (r_op == OP_INSERT) && out_free
                       && !fill_full;
    assign out_load  = ((r_state == S_FWAIT) && (r_op == OP_INSERT) && out_free)
                       || ((r_state == S_HIT) && (r_hits != HITS_W'(MAX_HITS))
                           && r_pend_v && out_free)
                       || ((r_state == S_FIN) && out_free);

    // bucket counts
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            fill_mem[r_ci] <= '0;
        end else if (ins_we) begin
            fill_mem[r_h] <= FW'(r_fill_q + 1'b1);
        end
        if (r_state == S_FREAD) begin
            r_fill_q <= fill_mem[r_rem[HW-1:0]];
        end
    end

    // entry store
    always_ff @(posedge i_clk) begin
        if (ins_we) begin
            ent_mem[AW'(AW'(r_h) * AW'(BUCKET_DEPTH)) + AW'(r_fill_q)] <=
                {r_qid, r_p[0], r_p[1], r_p[2]};
        end
        if (r_state == S_ENEXT) begin
            r_ent <= ent_mem[ent_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_ci       <= '0;
            r_ax       <= 2'd0;
            r_dcnt     <= '0;
            r_hits     <= '0;
            r_more     <= 1'b0;
            r_pend_v   <= 1'b0;
            r_o_valid  <= 1'b0;
            r_cell_len <= CELL_LEN_RST;
        end else begin
            if (i_cfg_we) begin
                r_cell_len <= i_cfg_data;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_CLR: begin
                    r_ci <= HW'(r_ci + 1'b1);
                    if (r_ci == HW'(TABLE_SIZE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= i_op;
                        r_qid    <= i_item_id;
                        r_p[0]   <= i_pos_x;
                        r_p[1]   <= i_pos_y;
                        r_p[2]   <= i_pos_z;
                        r_ax     <= 2'd0;
                        r_d[0]   <= 2'd1;
                        r_d[1]   <= 2'd1;
                        r_d[2]   <= 2'd1;
                        r_hits   <= '0;
                        r_more   <= 1'b0;
                        r_pend_v <= 1'b0;
                        r_dq     <= mag32(i_pos_x);
                        r_neg    <= i_pos_x[31];
                        r_dsr    <= len_eff;
                        r_rem    <= '0;
                        r_dcnt   <= '0;
                        r_ret    <= S_CELL;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= trial_ge ? trial - r_dsr : trial;
                    r_dq   <= {r_dq[30:0], trial_ge};
                    r_dcnt <= 6'(r_dcnt + 1'b1);
                    if (r_dcnt == 6'd31) begin
                        r_state <= r_ret;
                    end
                end
                S_CELL: begin
                    r_c[r_ax] <= qcell[31:0];
                    if (r_ax != 2'd2) begin
                        r_ax    <= 2'(r_ax + 1'b1);
                        r_dq    <= mag32(r_p[r_ax + 2'd1]);
                        r_neg   <= r_p[r_ax + 2'd1][31];
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_ax <= 2'd0;
                        if (r_op == OP_QUERY) begin
                            r_d[0]  <= 2'd0;
                            r_d[1]  <= 2'd0;
                            r_d[2]  <= 2'd0;
                            r_state <= S_LIM;
                        end else begin
                            r_state <= S_HMUL;
                        end
                    end
                end
                S_LIM: begin
                    r_state <= S_LIMW;
                end
                S_LIMW: begin
                    r_lim   <= r_prod;
                    r_state <= S_HMUL;
                end
                S_HMUL: begin
                    r_state <= S_HACC;
                end
                S_HACC: begin
                    r_hash <= ((r_ax == 2'd0) ? 32'd0 : r_hash) ^ r_prod[31:0];
                    if (r_ax != 2'd2) begin
                        r_ax    <= 2'(r_ax + 1'b1);
                        r_state <= S_HMUL;
                    end else begin
                        r_dq    <= r_hash ^ r_prod[31:0];
                        r_state <= S_MQ;
                    end
                end
                S_MQ: begin
                    r_state <= S_MQW;
                end
                S_MQW: begin
                    r_rem   <= r_prod[63:32];
                    r_state <= S_MR;
                end
                S_MR: begin
                    r_state <= S_MRW;
                end
                S_MRW: begin
                    r_rem   <= r_dq - r_prod[31:0];
                    r_state <= S_MFIX;
                end
                S_MFIX: begin
                    if (r_rem >= TBL32) begin
                        r_rem <= r_rem - TBL32;
                    end else begin
                        r_state <= S_FREAD;
                    end
                end
                S_FREAD: begin
                    r_h     <= r_rem[HW-1:0];
                    r_state <= S_FWAIT;
                end
                S_FWAIT: begin
                    if (r_op == OP_QUERY) begin
                        r_n     <= r_fill_q;
                        r_e     <= '0;
                        r_state <= S_ENEXT;
                    end else if (out_free) begin
                        r_o_status <= fill_full ? ST_FULL : ST_INSERTED;
                        r_o_nid    <= '0;
                        r_o_qid    <= r_qid;
                        r_o_last   <= 1'b1;
                        r_o_trunc  <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                S_ENEXT: begin
                    r_state <= (r_e == r_n) ? S_NADV : S_ECHK;
                end
                S_ECHK: begin
                    for (int a = 0; a < 3; a++) begin
                        r_dd[a] <= adiff[a][31:0];
                    end
                    r_ax <= 2'd0;
                    if (near) begin
                        r_state <= S_SQ;
                    end else begin
                        r_e     <= FW'(r_e + 1'b1);
                        r_state <= S_ENEXT;
                    end
                end
                S_SQ: begin
                    r_state <= S_SQACC;
                end
                S_SQACC: begin
                    r_acc <= ((r_ax == 2'd0) ? 64'd0 : r_acc) + r_prod;
                    if (r_ax != 2'd2) begin
                        r_ax    <= 2'(r_ax + 1'b1);
                        r_state <= S_SQ;
                    end else begin
                        r_ax    <= 2'd0;
                        r_state <= S_SQCMP;
                    end
                end
                S_SQCMP: begin
                    if (r_acc >= r_lim) begin
                        r_e     <= FW'(r_e + 1'b1);
                        r_state <= S_ENEXT;
                    end else begin
                        r_dq    <= mag32(ent_p[0]);
                        r_neg   <= ent_p[0][31];
                        r_dsr   <= len_eff;
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_ret   <= S_ECELL;
                        r_state <= S_DIV;
                    end
                end
                S_ECELL: begin
                    if (qcell != ncell[r_ax]) begin
                        r_e     <= FW'(r_e + 1'b1);
                        r_state <= S_ENEXT;
                    end else if (r_ax != 2'd2) begin
                        r_ax    <= 2'(r_ax + 1'b1);
                        r_dq    <= mag32(ent_p[r_ax + 2'd1]);
                        r_neg   <= ent_p[r_ax + 2'd1][31];
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_HIT;
                    end
                end
                S_HIT: begin
                    if (r_hits == HITS_W'(MAX_HITS)) begin
                        r_more  <= 1'b1;
                        r_e     <= FW'(r_e + 1'b1);
                        r_state <= S_ENEXT;
                    end else if (!r_pend_v || out_free) begin
                        // previous match is known not to be the last word
                        if (r_pend_v) begin
                            r_o_status <= ST_FOUND;
                            r_o_nid    <= r_pend_id;
                            r_o_qid    <= r_qid;
                            r_o_last   <= 1'b0;
                            r_o_trunc  <= 1'b0;
                        end
                        r_pend_v  <= 1'b1;
                        r_pend_id <= r_ent.id;
                        r_hits    <= HITS_W'(r_hits + 1'b1);
                        r_e       <= FW'(r_e + 1'b1);
                        r_state   <= S_ENEXT;
                    end
                end
                S_NADV: begin
                    r_ax    <= 2'd0;
                    r_state <= S_HMUL;
                    if (r_d[2] != 2'd2) begin
                        r_d[2] <= 2'(r_d[2] + 1'b1);
                    end else begin
                        r_d[2] <= 2'd0;
                        if (r_d[1] != 2'd2) begin
                            r_d[1] <= 2'(r_d[1] + 1'b1);
                        end else begin
                            r_d[1] <= 2'd0;
                            if (r_d[0] != 2'd2) begin
                                r_d[0] <= 2'(r_d[0] + 1'b1);
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_o_status <= r_pend_v ? ST_FOUND : ST_NONE;
                        r_o_nid    <= r_pend_v ? r_pend_id : '0;
                        r_o_qid    <= r_qid;
                        r_o_last   <= 1'b1;
                        r_o_trunc  <= r_more;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_o_valid;
    assign o_status       = r_o_status;
    assign o_neighbour_id = r_o_nid;
    assign o_query_id     = r_o_qid;
    assign o_last         = r_o_last;
    assign o_truncated    = r_o_trunc;

    a_clr_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_in_ready)
        else $error("input accepted during clearing pass");

    a_more_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_more |-> (r_hits == HITS_W'(MAX_HITS)))
        else $error("overflow flag set below hit cap");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_truncated) |-> (o_last && o_status == ST_FOUND))
        else $error("truncated word is not a final match");

    a_hit_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hits <= HITS_W'(MAX_HITS))
        else $error("hit count past cap");

endmodule

`default_nettype wire

FILE: verif/shns_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shns_checker
// Watches the input, result and cell-length ports of the neighbour search
// block, keeps its own copy of the hash grid and predicts every result
// word. Each accepted result is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module shns_checker #(
    parameter int TABLE_SIZE   = 1024,
    parameter int BUCKET_DEPTH = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [shns_pkg::LEN_W-1:0]    i_cfg_data,
    input  wire                          i_in_valid,
    input  wire                          i_in_ready,
    input  wire                          i_op,
    input  wire [shns_pkg::ID_W-1:0]     i_item_id,
    input  wire [shns_pkg::POS_W-1:0]    i_pos_x,
    input  wire [shns_pkg::POS_W-1:0]    i_pos_y,
    input  wire [shns_pkg::POS_W-1:0]    i_pos_z,
    input  wire                          i_out_valid,
    input  wire                          i_out_ready,
    input  wire [shns_pkg::STAT_W-1:0]   i_status,
    input  wire [shns_pkg::ID_W-1:0]     i_neighbour_id,
    input  wire [shns_pkg::ID_W-1:0]     i_query_id,
    input  wire                          i_last,
    input  wire                          i_truncated,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked
);
    import shns_pkg::*;

    localparam logic [31:0] TBL = TABLE_SIZE;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   nid;
        logic [ID_W-1:0]   qid;
        logic              last;
        logic              trunc;
    } t_result;

    t_result          expected_words[$];
    int               bucket_fill[TABLE_SIZE];
    logic [POS_W-1:0] grid_x[TABLE_SIZE*BUCKET_DEPTH];
    logic [POS_W-1:0] grid_y[TABLE_SIZE*BUCKET_DEPTH];
    logic [POS_W-1:0] grid_z[TABLE_SIZE*BUCKET_DEPTH];
    logic [ID_W-1:0]  grid_id[TABLE_SIZE*BUCKET_DEPTH];
    logic [LEN_W-1:0] cell_len;
    int               fails;
    int               checked;

    function automatic longint edge_len();
        return (cell_len == '0) ? 64'sd1 : longint'({33'b0, cell_len});
    endfunction

    function automatic longint cell_of(longint p);
        return p / edge_len();
    endfunction

    function automatic logic [31:0] bucket_of(longint ix, longint iy, longint iz);
        logic [31:0] hx, hy, hz;
        hx = ix[31:0] * HASH_PX;
        hy = iy[31:0] * HASH_PY;
        hz = iz[31:0] * HASH_PZ;
        return (hx ^ hy ^ hz) % TBL;
    endfunction

    task automatic predict_word(logic op, logic [ID_W-1:0] id,
                                logic [POS_W-1:0] rx, logic [POS_W-1:0] ry,
                                logic [POS_W-1:0] rz);
        longint px, py, pz, cx, cy, cz, len, ex, ey, ez, i, j, k;
        logic [63:0] lim, dx, dy, dz;
        logic [31:0] h;
        int n, s, hits;
        bit more;
        t_result r;
        t_result found[$];
        px = longint'(signed'(rx));
        py = longint'(signed'(ry));
        pz = longint'(signed'(rz));
        cx = cell_of(px);
        cy = cell_of(py);
        cz = cell_of(pz);
        len = edge_len();
        lim = len * len;
        hits = 0;
        more = 0;
        r = '0;
        r.qid = id;
        if (op == OP_INSERT) begin
            h = bucket_of(cx, cy, cz);
            n = bucket_fill[h];
            r.last = 1'b1;
            if (n >= BUCKET_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                s = h * BUCKET_DEPTH + n;
                grid_x[s] = rx;
                grid_y[s] = ry;
                grid_z[s] = rz;
                grid_id[s] = id;
                bucket_fill[h] = n + 1;
                r.status = ST_INSERTED;
            end
            expected_words = {expected_words, r};
            return;
        end
        for (i = cx - 1; i <= cx + 1; i++) begin
            for (j = cy - 1; j <= cy + 1; j++) begin
                for (k = cz - 1; k <= cz + 1; k++) begin
                    h = bucket_of(i, j, k);
                    n = bucket_fill[h];
                    for (int e = 0; e < n; e++) begin
                        s = h * BUCKET_DEPTH + e;
                        ex = longint'(signed'(grid_x[s]));
                        ey = longint'(signed'(grid_y[s]));
                        ez = longint'(signed'(grid_z[s]));
                        if (cell_of(ex) != i || cell_of(ey) != j || cell_of(ez) != k)
                            continue;
                        dx = (ex >= px) ? ex - px : px - ex;
                        dy = (ey >= py) ? ey - py : py - ey;
                        dz = (ez >= pz) ? ez - pz : pz - ez;
                        if (dx >= len || dy >= len || dz >= len)
                            continue;
                        if (dx * dx + dy * dy + dz * dz >= lim)
                            continue;
                        if (hits < MAX_HITS) begin
                            r.status = ST_FOUND;
                            r.nid = grid_id[s];
                            found = {found, r};
                            hits++;
                        end else begin
                            more = 1;
                        end
                    end
                end
            end
        end
        if (hits == 0) begin
            r.status = ST_NONE;
            r.nid = '0;
            r.last = 1'b1;
            found = {found, r};
        end else begin
            r = found.pop_back();
            r.last = 1'b1;
            r.trunc = more;
            found = {found, r};
        end
        expected_words = {expected_words, found};
    endtask

    task automatic check_word();
        t_result w;
        if (expected_words.size() == 0) begin
            $display("%0t: result word with nothing expected: status %0d id %0h",
                     $time, i_status, i_query_id);
            fails++;
            return;
        end
        w = expected_words.pop_front();
        checked++;
        if (i_status !== w.status) begin
            $display("%0t: status expected %0d actual %0d", $time, w.status, i_status);
            fails++;
        end
        if (i_neighbour_id !== w.nid) begin
            $display("%0t: neighbour_id expected %0h actual %0h",
                     $time, w.nid, i_neighbour_id);
            fails++;
        end
        if (i_query_id !== w.qid) begin
            $display("%0t: query_id expected %0h actual %0h", $time, w.qid, i_query_id);
            fails++;
        end
        if (i_last !== w.last) begin
            $display("%0t: last expected %0b actual %0b", $time, w.last, i_last);
            fails++;
        end
        if (i_truncated !== w.trunc) begin
            $display("%0t: truncated expected %0b actual %0b",
                     $time, w.trunc, i_truncated);
            fails++;
        end
    endtask

    initial begin
        fails = 0;
        checked = 0;
        cell_len = CELL_LEN_RST;
        o_fail_count = 0;
        o_pending = 0;
        o_checked = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (bucket_fill[b])
                bucket_fill[b] = 0;
            cell_len = CELL_LEN_RST;
            expected_words.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_word();
            if (i_cfg_we)
                cell_len = i_cfg_data;
            if (i_in_valid && i_in_ready)
                predict_word(i_op, i_item_id, i_pos_x, i_pos_y, i_pos_z);
        end
        o_fail_count <= fails;
        o_pending <= expected_words.size();
        o_checked <= checked;
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the spatial hash neighbour search block: directed corner
// words, then clustered and noise words over several cell lengths, with
// random idling on both channels and one long receiver stall.
// ----------------------------------------------------------------------------
module tb_top;
    import shns_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [LEN_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              op = OP_INSERT;
    logic [ID_W-1:0]   item_id = '0;
    logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   neighbour_id, query_id;
    logic              last, truncated;
    int                fail_count, pending, checked;

    int     tx_idle, rx_idle, words_sent, settings_used;
    bit     hold_req;
    longint cur_len;

    always #4 clk = ~clk;

    spatial_hash_neighbour_search dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_op(op),
        .i_item_id(item_id), .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_status(status),
        .o_neighbour_id(neighbour_id), .o_query_id(query_id), .o_last(last),
        .o_truncated(truncated)
    );

    shns_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_op(op),
        .i_item_id(item_id), .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_status(status),
        .i_neighbour_id(neighbour_id), .i_query_id(query_id), .i_last(last),
        .i_truncated(truncated), .o_fail_count(fail_count), .o_pending(pending),
        .o_checked(checked)
    );

    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 0;
                out_ready <= 1'b0;
                repeat (2500) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic send_word(logic o, logic [ID_W-1:0] id, logic [31:0] x,
                             logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < tx_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        op <= o;
        item_id <= id;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        in_valid <= 1'b1;
        do @(posedge clk); while (!(in_valid && in_ready));
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_len(logic [LEN_W-1:0] v);
        drain();
        cfg_data <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_len = (v == 0) ? 1 : longint'({33'b0, v});
        settings_used++;
    endtask

    function automatic logic [31:0] near(logic [31:0] c);
        longint off;
        off = longint'({32'b0, $urandom}) % (2 * cur_len + 1) - cur_len;
        return 32'(longint'(signed'(c)) + off);
    endfunction

    task automatic run_phase(int count, int ins_pct);
        logic [31:0] cx, cy, cz;
        logic o;
        cx = $urandom;
        cy = $urandom;
        cz = $urandom;
        for (int n = 0; n < count; n++) begin
            o = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_QUERY;
            if ($urandom_range(99) < 75)
                send_word(o, 16'($urandom), near(cx), near(cy), near(cz));
            else
                send_word(1'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
        end
    endtask

    task automatic dense_phase();
        logic [31:0] cx, cy, cz;
        cx = $urandom;
        cy = $urandom;
        cz = $urandom;
        for (int n = 0; n < 150; n++)
            send_word(OP_INSERT, 16'($urandom), near(cx), near(cy), near(cz));
        drain();
        hold_req = 1;
        for (int n = 0; n < 8; n++)
            send_word(OP_QUERY, 16'($urandom), cx + 32'(n), cy, cz - 32'(n));
    endtask

    initial begin
        tx_idle = 16;
        rx_idle = 66;
        words_sent = 0;
        settings_used = 1;
        hold_req = 0;
        cur_len = CELL_LEN_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(OP_INSERT, 16'h0000, 32'h0, 32'h0, 32'h0);
        send_word(OP_QUERY, 16'hFFFF, 32'h0, 32'h0, 32'h0);
        send_word(OP_QUERY, 16'h0001, 32'h10000, 32'h0, 32'h0);
        send_word(OP_QUERY, 16'h0002, 32'h8000, 32'h8000, 32'h8000);
        send_word(OP_INSERT, 16'h0001, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_word(OP_QUERY, 16'h0003, 32'h0, 32'h0, 32'h0);
        send_word(OP_INSERT, 16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_word(OP_QUERY, 16'h0004, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_word(OP_INSERT, 16'h8000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_word(OP_QUERY, 16'h0005, 32'h80000000, 32'h80000000, 32'h80000000);
        // overfill one bucket
        for (int n = 0; n < 9; n++)
            send_word(OP_INSERT, 16'h0100 + 16'(n), 32'h30000, 32'h50000, 32'h70000);
        send_word(OP_QUERY, 16'h0006, 32'h30000, 32'h50000, 32'h70000);

        write_len(31'd1);
        // neighbour cells beyond the 32-bit range
        send_word(OP_INSERT, 16'h0200, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_word(OP_QUERY, 16'h0201, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_word(OP_QUERY, 16'h0202, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        run_phase(40, 60);
        write_len(31'h7FFFFFFF);
        run_phase(40, 60);

        tx_idle = 66;
        rx_idle = 16;
        write_len(31'd0);
        run_phase(30, 60);
        write_len(31'd4096);
        dense_phase();

        tx_idle = 0;
        rx_idle = 0;
        write_len(31'($urandom_range(32'h7FFFFFFF, 1)));
        run_phase(40, 50);
        write_len(CELL_LEN_RST);
        run_phase(30, 60);
        drain();
        run_phase(30, 40);

        drain();
        $display("Covered %0d input words over %0d cell-length settings,", words_sent,
                 settings_used);
        $display("with %0d result words compared incl. full buckets and overflow.",
                 checked);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #400_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
